// ===== rtl/rmrs_pkg.sv =====
// shared types, command codes and wiring tables for the row scan controller
`default_nettype none

package rmrs_pkg;

    // default geometry
    localparam int RMRS_COLUMNS   = 16;
    localparam int RMRS_ROWS      = 8;
    localparam int RMRS_CHANNELS  = 48;
    localparam int RMRS_MSG_DEPTH = 256;

    localparam int NUM_COLORS = 3;
    localparam int WIRED      = 48;

    localparam logic [11:0] BRIGHT_RESET = 12'hFFF;

    // command codes
    localparam logic [2:0] CMD_WRITE_COL = 3'd0;
    localparam logic [2:0] CMD_LOAD_MSG  = 3'd1;
    localparam logic [2:0] CMD_SCROLL    = 3'd2;
    localparam logic [2:0] CMD_SCAN      = 3'd3;
    localparam logic [2:0] CMD_BLANK     = 3'd4;

    // frame column of the pixel carried by each driver channel
    localparam logic [3:0] SLOT_COL [WIRED] = '{
        4'd8,  4'd8,  4'd9,  4'd10, 4'd10, 4'd11, 4'd12, 4'd12,
        4'd13, 4'd14, 4'd14, 4'd15, 4'd7,  4'd6,  4'd6,  4'd5,
        4'd4,  4'd4,  4'd3,  4'd2,  4'd2,  4'd1,  4'd0,  4'd0,
        4'd0,  4'd1,  4'd1,  4'd2,  4'd3,  4'd3,  4'd4,  4'd5,
        4'd5,  4'd6,  4'd7,  4'd7,  4'd15, 4'd15, 4'd14, 4'd13,
        4'd13, 4'd12, 4'd11, 4'd11, 4'd10, 4'd9,  4'd9,  4'd8
    };

    // color plane of the pixel carried by each driver channel
    localparam logic [1:0] SLOT_CLR [WIRED] = '{
        2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd2, 2'd0,
        2'd1, 2'd2, 2'd0, 2'd1, 2'd1, 2'd0, 2'd2, 2'd1,
        2'd0, 2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
        2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd1, 2'd2,
        2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd2, 2'd1, 2'd0,
        2'd2, 2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2
    };

    // one request
    typedef struct packed {
        logic [2:0] cmd;
        logic [1:0] color;
        logic [3:0] column;
        logic [7:0] msg_index;
        logic [7:0] value;
        logic [8:0] shift;
        logic [8:0] msg_len;
        logic [2:0] row;
    } t_req;

    // one result
    typedef struct packed {
        logic [5:0]  channel;
        logic [11:0] level;
        logic [7:0]  row_select;
        logic        last;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic wr_col;
        logic wr_msg;
        logic scroll;
        logic scan;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       color_ok;
        logic       col_last;
        logic       ch_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/rmrs_ctrl.sv =====
// sequencer that steps the datapath through one request at a time
`default_nettype none

module rmrs_ctrl
    import rmrs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_sts i_sts,
    output t_ctl      o_ctl,
    output logic      o_busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCROLL = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.cmd) inside
                    CMD_WRITE_COL: begin
                        o_ctl.wr_col = 1'b1;
                        n_state      = S_IDLE;
                    end
                    CMD_LOAD_MSG: begin
                        o_ctl.wr_msg = 1'b1;
                        n_state      = S_IDLE;
                    end
                    CMD_SCROLL: begin
                        n_state = i_sts.color_ok ? S_SCROLL : S_IDLE;
                    end
                    CMD_SCAN, CMD_BLANK: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCROLL: begin
                o_ctl.scroll = 1'b1;
                if (i_sts.col_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.ch_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/rmrs_dp.sv =====
// frame and message stores, scroll copy and row scan result pipeline
`default_nettype none

module rmrs_dp
    import rmrs_pkg::*;
#(
    parameter int COLUMNS   = RMRS_COLUMNS,
    parameter int ROWS      = RMRS_ROWS,
    parameter int CHANNELS  = RMRS_CHANNELS,
    parameter int MSG_DEPTH = RMRS_MSG_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_req        i_req,
    input  wire t_ctl        i_ctl,
    output t_sts             o_sts,
    input  wire logic        i_cfg_we,
    input  wire logic [11:0] i_cfg_data,
    output logic             o_res_strobe,
    output t_res             o_res
);

    localparam int FD  = NUM_COLORS * COLUMNS;
    localparam int FAW = $clog2(FD);
    localparam int MD  = NUM_COLORS * MSG_DEPTH;
    localparam int MAW = $clog2(MD);
    localparam int CW  = $clog2(CHANNELS > COLUMNS ? CHANNELS : COLUMNS);

    // latched request, step counter, brightness
    t_req        r_req;
    logic [CW-1:0] r_cnt;
    logic [11:0] r_bright;

    // stores
    logic [7:0] r_fs_mem [FD];
    logic       r_fs_vld [FD];
    logic [7:0] r_fs_rd;
    logic       r_fs_rdv;
    logic [7:0] r_ms_mem [MD];
    logic [7:0] r_ms_rd;

    // pipeline registers
    logic           r_sc_wr;
    logic           r_sc_ok;
    logic [FAW-1:0] r_sc_fa;
    logic           r_sn_v;
    logic [5:0]     r_sn_ch;
    logic           r_sn_hit;
    logic           r_sn_last;
    logic           r_strobe;
    t_res           r_res;

    logic           color_ok;
    logic           lit;
    logic [9:0]     sc_base;
    logic [9:0]     sc_pos;
    logic           sc_ok;
    logic [MAW-1:0] ms_ra;
    logic [FAW-1:0] sc_fa;
    logic           ms_we;
    logic [MAW-1:0] ms_wa;
    logic           fs_we;
    logic [FAW-1:0] fs_wa;
    logic [7:0]     fs_wd;
    logic           ch_wired;
    logic [5:0]     tab_idx;
    logic [3:0]     sn_col;
    logic [1:0]     sn_clr;
    logic           sn_hit;
    logic [FAW-1:0] fs_ra;

    assign color_ok = (32'(r_req.color) < NUM_COLORS);
    assign lit      = (r_req.cmd == CMD_SCAN) && (32'(r_req.row) < ROWS);

    // request latch and step counter
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= '0;
        end else if (i_ctl.scroll || i_ctl.scan) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // brightness register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= BRIGHT_RESET;
        end else if (i_cfg_we) begin
            r_bright <= i_cfg_data;
        end
    end

    // scroll window position, zero outside the message
    assign sc_base = 10'(r_req.shift) + 10'(r_cnt);
    assign sc_pos  = sc_base - 10'(COLUMNS);
    assign sc_ok   = (sc_base >= 10'(COLUMNS)) && (sc_pos < 10'(r_req.msg_len))
                     && (32'(sc_pos) < MSG_DEPTH);
    assign ms_ra   = sc_ok ? MAW'(32'(r_req.color) * MSG_DEPTH + 32'(sc_pos)) : '0;
    assign sc_fa   = FAW'(32'(r_req.color) * COLUMNS + 32'(r_cnt));

    // message store write
    assign ms_we = i_ctl.wr_msg && color_ok && (32'(r_req.msg_index) < MSG_DEPTH);
    assign ms_wa = ms_we ? MAW'(32'(r_req.color) * MSG_DEPTH + 32'(r_req.msg_index)) : '0;

    always_ff @(posedge i_clk) begin
        if (ms_we) begin
            r_ms_mem[ms_wa] <= r_req.value;
        end
        if (i_ctl.scroll) begin
            r_ms_rd <= r_ms_mem[ms_ra];
        end
    end

    // scroll write stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_wr <= 1'b0;
        end else begin
            r_sc_wr <= i_ctl.scroll;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sc_ok <= sc_ok;
        r_sc_fa <= sc_fa;
    end

    // frame store write port: scroll copy or column write
    always_comb begin
        fs_we = 1'b0;
        fs_wa = '0;
        fs_wd = '0;
        if (r_sc_wr) begin
            fs_we = 1'b1;
            fs_wa = r_sc_fa;
            fs_wd = r_sc_ok ? r_ms_rd : 8'd0;
        end else if (i_ctl.wr_col && color_ok && (32'(r_req.column) < COLUMNS)) begin
            fs_we = 1'b1;
            fs_wa = FAW'(32'(r_req.color) * COLUMNS + 32'(r_req.column));
            fs_wd = r_req.value;
        end
    end

    // scan address from the wiring table
    assign ch_wired = (32'(r_cnt) < WIRED);
    assign tab_idx  = ch_wired ? 6'(r_cnt) : '0;
    assign sn_col   = SLOT_COL[tab_idx];
    assign sn_clr   = SLOT_CLR[tab_idx];
    assign sn_hit   = lit && ch_wired && (32'(sn_col) < COLUMNS);
    assign fs_ra    = sn_hit ? FAW'(32'(sn_clr) * COLUMNS + 32'(sn_col)) : '0;

    // frame store array
    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            r_fs_mem[fs_wa] <= fs_wd;
        end
        if (i_ctl.scan) begin
            r_fs_rd <= r_fs_mem[fs_ra];
        end
    end

    // frame valid bits, cleared at reset so unwritten columns read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FD; i++) begin
                r_fs_vld[i] <= 1'b0;
            end
            r_fs_rdv <= 1'b0;
        end else begin
            if (fs_we) begin
                r_fs_vld[fs_wa] <= 1'b1;
            end
            if (i_ctl.scan) begin
                r_fs_rdv <= r_fs_vld[fs_ra];
            end
        end
    end

    // scan read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sn_v <= 1'b0;
        end else begin
            r_sn_v <= i_ctl.scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sn_ch   <= 6'(r_cnt);
        r_sn_hit  <= sn_hit;
        r_sn_last <= (r_cnt == CW'(CHANNELS - 1));
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_sn_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.channel    <= r_sn_ch;
        r_res.level      <= (r_sn_hit && r_fs_rdv && r_fs_rd[~r_req.row]) ? r_bright : 12'd0;
        r_res.row_select <= lit ? (8'd1 << r_req.row) : 8'd0;
        r_res.last       <= r_sn_last;
    end

    // status back to the sequencer
    assign o_sts.cmd      = r_req.cmd;
    assign o_sts.color_ok = color_ok;
    assign o_sts.col_last = (r_cnt == CW'(COLUMNS - 1));
    assign o_sts.ch_last  = (r_cnt == CW'(CHANNELS - 1));

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

endmodule

`default_nettype wire

// ===== rtl/rgb_matrix_row_scan_controller.sv =====
// top level of the rgb matrix row scan controller
`default_nettype none

// One request at a time: a request is taken when start is high and busy is low.
// Column write and message load hold busy for the decode state only, a scroll on
// a valid color for decode, scroll and flush (one window column copied per cycle
// through the message store read port), a scan or blank for decode, scan and
// flush (one driver channel per cycle through the frame store read port). Scan
// results leave one per cycle on o_res, marked by o_res_strobe, through the scan
// read stage and result register; the receiver cannot stall them, every strobe
// is a finished result. The frame store reads as zero right after reset with no
// clearing pass; message bytes must be loaded before a scroll shows them.
// Brightness may be written any time the block is idle and is never refused.
module rgb_matrix_row_scan_controller
    import rmrs_pkg::*;
#(
    parameter int COLUMNS   = RMRS_COLUMNS,
    parameter int ROWS      = RMRS_ROWS,
    parameter int CHANNELS  = RMRS_CHANNELS,
    parameter int MSG_DEPTH = RMRS_MSG_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire t_req        i_req,
    output logic             busy,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [11:0] i_cfg_data,
    output logic             o_res_strobe,
    output t_res             o_res
);

    t_ctl ctl;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    // sequencer
    rmrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // stores and result pipeline
    rmrs_dp #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .CHANNELS  (CHANNELS),
        .MSG_DEPTH (MSG_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

`ifndef ASSERT_OFF
    // an accepted request makes the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // a run of results has no gaps before its last result
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_res.last) |=> o_res_strobe)
        else $error("gap inside a result run");

    // nothing follows the last result of a run directly
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.last) |=> !o_res_strobe)
        else $error("result right after end of run");

    // at most one row driven
    a_row_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $onehot0(o_res.row_select))
        else $error("more than one row driven");
`endif

endmodule

`default_nettype wire

// ===== sim/rmrs_scan_checker.sv =====
// request watcher, row level predictor and result comparator for the row scan controller
`timescale 1ns / 100ps

module rmrs_scan_checker
    import rmrs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire t_req        i_req,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [11:0] i_cfg_data,
    input  wire logic        i_res_strobe,
    input  wire t_res        i_res,
    output int               o_errors,
    output int               o_pending
);

    // logical slot (column*3 + color) carried by each driver channel
    localparam int WIRE_SLOT [RMRS_CHANNELS] = '{
        25, 24, 29, 31, 30, 35, 38, 36, 40, 44, 42, 46,
        22, 18, 20, 16, 12, 14, 11, 6, 7, 5, 0, 1,
        2, 4, 3, 8, 10, 9, 13, 17, 15, 19, 23, 21,
        45, 47, 43, 39, 41, 37, 33, 34, 32, 27, 28, 26
    };

    logic [7:0]  frame_bits    [NUM_COLORS][RMRS_COLUMNS];
    logic [7:0]  message_bytes [NUM_COLORS][RMRS_MSG_DEPTH];
    logic [11:0] lit_level;
    t_res        due_levels [$];
    int          error_count = 0;

    initial begin
        foreach (message_bytes[c, p]) message_bytes[c][p] = 8'h00;
    end

    // queue the 48 channel levels of one scan or blank run
    task automatic queue_row_levels(input logic scan, input logic [2:0] row);
        t_res lv;
        int   slot;
        for (int ch = 0; ch < RMRS_CHANNELS; ch++) begin
            slot          = WIRE_SLOT[ch];
            lv.channel    = 6'(ch);
            lv.level      = 12'h000;
            lv.row_select = scan ? (8'h01 << row) : 8'h00;
            lv.last       = (ch == RMRS_CHANNELS - 1);
            if (scan && frame_bits[slot % NUM_COLORS][slot / NUM_COLORS][3'd7 - row]) begin
                lv.level = lit_level;
            end
            due_levels.push_back(lv);
        end
    endtask

    // update the frame and message copies for one accepted request
    task automatic apply_request(input t_req r);
        int         pos;
        int         len;
        logic [7:0] b;
        len = int'(r.msg_len);
        case (r.cmd)
            CMD_WRITE_COL: begin
                if (r.color < NUM_COLORS) frame_bits[r.color][r.column] = r.value;
            end
            CMD_LOAD_MSG: begin
                if (r.color < NUM_COLORS) message_bytes[r.color][r.msg_index] = r.value;
            end
            CMD_SCROLL: begin
                if (r.color < NUM_COLORS) begin
                    // window column j shows message position shift - COLUMNS + j
                    for (int j = 0; j < RMRS_COLUMNS; j++) begin
                        pos = int'(r.shift) + j - RMRS_COLUMNS;
                        b   = 8'h00;
                        if (pos >= 0 && pos < len && pos < RMRS_MSG_DEPTH) begin
                            b = message_bytes[r.color][pos];
                        end
                        frame_bits[r.color][j] = b;
                    end
                end
            end
            CMD_SCAN:  queue_row_levels(1'b1, r.row);
            CMD_BLANK: queue_row_levels(1'b0, 3'd0);
            default: ;
        endcase
    endtask

    // compare one result with the oldest queued level
    task automatic check_level(input t_res got);
        t_res want;
        if (due_levels.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
                $display("[%0t] unexpected result: ch %0d level %0d sel %h last %b",
                         $realtime, got.channel, got.level, got.row_select, got.last);
            end
            return;
        end
        want = due_levels.pop_front();
        if (got.channel !== want.channel || got.level !== want.level ||
            got.row_select !== want.row_select || got.last !== want.last) begin
            error_count++;
            if (error_count <= 10) begin
                $display("[%0t] result mismatch: exp ch %0d level %0d sel %h last %b",
                         $realtime, want.channel, want.level, want.row_select, want.last);
                $display("[%0t]                  got ch %0d level %0d sel %h last %b",
                         $realtime, got.channel, got.level, got.row_select, got.last);
            end
        end
    endtask

    // watch the config, result and request channels at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lit_level = BRIGHT_RESET;
            foreach (frame_bits[c, k]) frame_bits[c][k] = 8'h00;
            due_levels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) lit_level = i_cfg_data;
            if (i_res_strobe) check_level(i_res);
            if (i_start && !i_busy) apply_request(i_req);
        end
        o_errors  <= error_count;
        o_pending <= due_levels.size();
    end

endmodule

// ===== sim/rgb_matrix_row_scan_controller_tb.sv =====
// stimulus and verdict for the rgb matrix row scan controller
`timescale 1ns / 100ps

module rgb_matrix_row_scan_controller_tb;
    import rmrs_pkg::*;

    localparam logic [1:0] COLOR_RED   = 2'd0;
    localparam logic [1:0] COLOR_GREEN = 2'd1;
    localparam logic [1:0] COLOR_BLUE  = 2'd2;
    localparam logic [1:0] COLOR_NONE  = 2'd3;

    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    t_req        req         = '0;
    logic        busy;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [11:0] cfg_data    = 12'h000;
    logic        res_strobe;
    t_res        res;
    int          errors;
    int          pending;

    // message positions loaded so far, so a scroll never reads an unwritten byte
    bit          msg_written [3][RMRS_MSG_DEPTH];
    logic [7:0]  load_ptr    [3] = '{8'd0, 8'd0, 8'd0};
    bit          sender_idles    = 1'b1;
    int          items_done      = 0;

    rgb_matrix_row_scan_controller u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_req        (req),
        .busy         (busy),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_res_strobe (res_strobe),
        .o_res        (res)
    );

    rmrs_scan_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_res_strobe (res_strobe),
        .i_res        (res),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_req make_req(input logic [2:0] cmd, input logic [1:0] color,
                                      input logic [3:0] column, input logic [7:0] idx,
                                      input logic [7:0] value, input logic [8:0] shift,
                                      input logic [8:0] len, input logic [2:0] row);
        t_req r;
        r = '{cmd, color, column, idx, value, shift, len, row};
        return r;
    endfunction

    // all fields random within range, a scan unless changed
    function automatic t_req rand_req();
        t_req r;
        r.cmd       = CMD_SCAN;
        r.color     = 2'($urandom_range(COLOR_RED, COLOR_BLUE));
        r.column    = 4'($urandom_range(0, RMRS_COLUMNS - 1));
        r.msg_index = 8'($urandom_range(0, RMRS_MSG_DEPTH - 1));
        r.value     = ($urandom_range(0, 7) == 0) ? {8{$urandom_range(0, 1) == 1}}
                                                  : 8'($urandom_range(0, 255));
        r.shift     = 9'($urandom_range(0, RMRS_MSG_DEPTH + RMRS_COLUMNS - 1));
        r.msg_len   = 9'($urandom_range(0, RMRS_MSG_DEPTH));
        r.row       = 3'($urandom_range(0, RMRS_ROWS - 1));
        return r;
    endfunction

    // shorten a scroll length so every message byte it shows has been loaded
    function automatic logic [8:0] safe_len(input logic [1:0] c, input logic [8:0] sh,
                                            input logic [8:0] len);
        int lo;
        int p;
        if (c == COLOR_NONE) return len;
        lo = (sh > RMRS_COLUMNS) ? int'(sh) - RMRS_COLUMNS : 0;
        p  = lo;
        while (p < RMRS_MSG_DEPTH && msg_written[c][p]) p++;
        if (int'(sh) <= p) return len;
        if (int'(len) > p) return 9'($urandom_range(0, p));
        return len;
    endfunction

    // present one request and hold it until the block takes it
    task automatic issue(input t_req r);
        while (sender_idles && $urandom_range(99) < 11) begin
            start <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(2, 60) : 1) @(posedge i_clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (r.cmd == CMD_LOAD_MSG && r.color != COLOR_NONE) msg_written[r.color][r.msg_index] = 1'b1;
        if (r.cmd <= CMD_BLANK && (r.cmd >= CMD_SCAN || r.color != COLOR_NONE)) items_done++;
    endtask

    // stop sending until every queued level has come back, then let the block settle
    task automatic drain(input int settle);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_brightness(input logic [11:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // random mix of scans, blanks, column writes, message loads, message bursts with scrolls, plain scrolls, and noise
    task automatic run_mix(input int target);
        t_req       r;
        int         pick;
        int         k;
        logic [1:0] c;
        items_done = 0;
        while (items_done < target) begin
            pick = $urandom_range(99);
            r    = rand_req();
            if (pick < 30) begin
                issue(r);
            end else if (pick < 38) begin
                r.cmd = CMD_BLANK;
                issue(r);
            end else if (pick < 52) begin
                r.cmd = CMD_WRITE_COL;
                issue(r);
            end else if (pick < 70) begin
                // load a run of message bytes, scroll over it, look at it
                c = 2'($urandom_range(COLOR_RED, COLOR_BLUE));
                k = $urandom_range(2, 8);
                repeat (k) begin
                    r           = rand_req();
                    r.cmd       = CMD_LOAD_MSG;
                    r.color     = c;
                    r.msg_index = load_ptr[c];
                    load_ptr[c] = load_ptr[c] + 8'd1;
                    issue(r);
                end
                r         = rand_req();
                r.cmd     = CMD_SCROLL;
                r.color   = c;
                r.shift   = 9'(int'(load_ptr[c]) + $urandom_range(0, RMRS_COLUMNS));
                r.msg_len = safe_len(c, r.shift, r.msg_len);
                issue(r);
                repeat ($urandom_range(1, 2)) issue(rand_req());
            end else if (pick < 82) begin
                r.cmd     = CMD_SCROLL;
                r.color   = ($urandom_range(0, 5) == 0) ? COLOR_NONE : r.color;
                r.msg_len = safe_len(r.color, r.shift, r.msg_len);
                issue(r);
            end else if (pick < 90) begin
                r.cmd = CMD_LOAD_MSG;
                issue(r);
            end else begin
                // commands the block ignores
                if ($urandom_range(0, 1) == 0) begin
                    r.cmd = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
                end else begin
                    r.cmd   = 3'($urandom_range(CMD_WRITE_COL, CMD_SCROLL));
                    r.color = COLOR_NONE;
                end
                issue(r);
            end
        end
    endtask

    // directed part, then random phases under several brightness settings
    initial begin
        logic [11:0] level_plan [6];
        level_plan[0] = 12'h000;
        level_plan[1] = 12'hFFF;
        level_plan[2] = 12'h001;
        level_plan[3] = 12'hAAA;
        level_plan[4] = 12'h555;
        level_plan[5] = 12'($urandom_range(0, 4095));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // frame is clear after reset, at reset brightness
        issue(make_req(CMD_SCAN, COLOR_RED, 4'd0, 8'd0, 8'h00, 9'd0, 9'd0, 3'd0));
        issue(make_req(CMD_BLANK, COLOR_RED, 4'd0, 8'd0, 8'h00, 9'd0, 9'd0, 3'd0));
        // column writes at both ends, one on a color with no plane
        issue(make_req(CMD_WRITE_COL, COLOR_RED, 4'd0, 8'd0, 8'hFF, 9'd0, 9'd0, 3'd0));
        issue(make_req(CMD_WRITE_COL, COLOR_BLUE, 4'd15, 8'd0, 8'h80, 9'd0, 9'd0, 3'd0));
        issue(make_req(CMD_WRITE_COL, COLOR_GREEN, 4'd7, 8'd0, 8'h01, 9'd0, 9'd0, 3'd0));
        issue(make_req(CMD_WRITE_COL, COLOR_NONE, 4'd3, 8'd0, 8'hFF, 9'd0, 9'd0, 3'd0));
        issue(make_req(CMD_SCAN, COLOR_RED, 4'd0, 8'd0, 8'h00, 9'd0, 9'd0, 3'd7));
        issue(make_req(CMD_SCAN, COLOR_RED, 4'd0, 8'd0, 8'h00, 9'd0, 9'd0, 3'd0));
        // message bytes at both ends of the store
        issue(make_req(CMD_LOAD_MSG, COLOR_RED, 4'd0, 8'd0, 8'hA5, 9'd0, 9'd0, 3'd0));
        issue(make_req(CMD_LOAD_MSG, COLOR_RED, 4'd0, 8'd255, 8'hFF, 9'd0, 9'd0, 3'd0));
        issue(make_req(CMD_LOAD_MSG, COLOR_NONE, 4'd0, 8'd1, 8'h77, 9'd0, 9'd0, 3'd0));
        // scroll to the far end, where only the last message byte shows
        issue(make_req(CMD_SCROLL, COLOR_RED, 4'd0, 8'd0, 8'h00, 9'd271, 9'd256, 3'd0));
        issue(make_req(CMD_SCAN, COLOR_RED, 4'd0, 8'd0, 8'h00, 9'd0, 9'd0, 3'd0));
        // window cut short by the message length
        issue(make_req(CMD_SCROLL, COLOR_RED, 4'd0, 8'd0, 8'h00, 9'd16, 9'd1, 3'd0));
        issue(make_req(CMD_SCAN, COLOR_RED, 4'd0, 8'd0, 8'h00, 9'd0, 9'd0, 3'd0));
        // window wholly before the message, and a scroll with no plane
        issue(make_req(CMD_SCROLL, COLOR_GREEN, 4'd0, 8'd0, 8'h00, 9'd0, 9'd0, 3'd0));
        issue(make_req(CMD_SCROLL, COLOR_NONE, 4'd0, 8'd0, 8'h00, 9'd100, 9'd200, 3'd0));
        // unused commands
        issue(make_req(CMD_FIRST_UNUSED, COLOR_RED, 4'd0, 8'd0, 8'h00, 9'd0, 9'd0, 3'd3));
        issue(make_req(CMD_LAST_UNUSED, COLOR_BLUE, 4'd15, 8'd255, 8'hFF, 9'd271, 9'd256, 3'd7));
        issue(make_req(CMD_SCAN, COLOR_RED, 4'd0, 8'd0, 8'h00, 9'd0, 9'd0, 3'd3));
        issue(make_req(CMD_WRITE_COL, COLOR_GREEN, 4'd10, 8'd0, 8'h5A, 9'd0, 9'd0, 3'd0));
        issue(make_req(CMD_SCAN, COLOR_RED, 4'd0, 8'd0, 8'h00, 9'd0, 9'd0, 3'd6));
        issue(make_req(CMD_BLANK, COLOR_BLUE, 4'd9, 8'd9, 8'hFF, 9'd9, 9'd9, 3'd5));
        drain(RMRS_COLUMNS + 4);

        for (int phase = 0; phase < 6; phase++) begin
            // phase 2 runs back to back with no sender gaps
            sender_idles = (phase != 2);
            write_brightness(level_plan[phase]);
            run_mix(28);
            drain(RMRS_COLUMNS + 4);
        end

        repeat (RMRS_CHANNELS + 10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
